/* sv/katan_pkg.sv */
// shared types, constants and lookup functions for the katan cipher core
// no dependencies; used by katan_keysched, katan_round and the top level
`default_nettype none

package katan_pkg;

    localparam int MAX_ROUNDS_DEF = 254;
    localparam int KEY_BITS       = 80;
    localparam int BLOCK_W        = 64;
    localparam int L1_W           = 25;
    localparam int L2_W           = 39;

    // configuration register indexes
    localparam logic [1:0] REG_BLOCK_SIZE_MODE = 2'd0;
    localparam logic [1:0] REG_ROUND_COUNT     = 2'd1;
    localparam logic [1:0] REG_START_ROUND     = 2'd2;

    // block size modes
    localparam logic [1:0] MODE_32 = 2'd0;
    localparam logic [1:0] MODE_48 = 2'd1;

    // key lfsr taps, forward: k[i+80] = k[i] ^ k[i+19] ^ k[i+30] ^ k[i+67]
    localparam int KT_A = 19;
    localparam int KT_B = 30;
    localparam int KT_C = 67;

    // round constant sequence, leftmost bit is round 0
    localparam logic [0:253] IR_SEQ = {
        30'b1111111000_1101010101_1110110011,
        30'b0010100100_0100011000_1111000010,
        30'b0001010000_0111110011_1111010100,
        30'b0101010011_0000110011_1011111011,
        30'b1010010101_1010011100_1101100010,
        30'b1110110111_1001011011_0101110010,
        30'b0100110100_0111000100_1111010000,
        30'b1110101100_0001011001_0000001101,
        14'b1100000001_0010
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROLL,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic fwd;
        logic back;
    } ks_ctrl_t;

    typedef struct packed {
        logic load;
        logic step;
        logic dir;
        logic ir;
        logic ka;
        logic kb;
    } rnd_ctrl_t;

    typedef struct packed {
        logic [4:0]      x0;
        logic [4:0]      x1;
        logic [4:0]      x2;
        logic [4:0]      x3;
        logic [4:0]      x4;
        logic [5:0]      y0;
        logic [5:0]      y1;
        logic [5:0]      y2;
        logic [5:0]      y3;
        logic [5:0]      y4;
        logic [5:0]      y5;
        logic [4:0]      top1;
        logic [5:0]      top2;
        logic [L1_W-1:0] m1;
        logic [L2_W-1:0] m2;
        logic [1:0]      reps;
    } geom_t;

    function automatic logic ir_bit(input logic [7:0] r);
        logic b;
        b = 1'b0;
        if (r < 8'd254)
        begin
            b = IR_SEQ[r];
        end
        return b;
    endfunction

    // unused mode 3 runs as the 64-bit block
    function automatic geom_t geometry(input logic [1:0] mode);
        geom_t g;
        unique case (mode)
            MODE_32:
            begin
                g = '{x0: 5'd12, x1: 5'd7, x2: 5'd8, x3: 5'd5, x4: 5'd3,
                      y0: 6'd18, y1: 6'd7, y2: 6'd12, y3: 6'd10, y4: 6'd8, y5: 6'd3,
                      top1: 5'd12, top2: 6'd18,
                      m1: 25'h0001FFF, m2: 39'h000007FFFF, reps: 2'd1};
            end
            MODE_48:
            begin
                g = '{x0: 5'd18, x1: 5'd12, x2: 5'd15, x3: 5'd7, x4: 5'd6,
                      y0: 6'd28, y1: 6'd19, y2: 6'd21, y3: 6'd13, y4: 6'd15, y5: 6'd6,
                      top1: 5'd18, top2: 6'd28,
                      m1: 25'h007FFFF, m2: 39'h001FFFFFFF, reps: 2'd2};
            end
            default:
            begin
                g = '{x0: 5'd24, x1: 5'd15, x2: 5'd20, x3: 5'd11, x4: 5'd9,
                      y0: 6'd38, y1: 6'd25, y2: 6'd33, y3: 6'd21, y4: 6'd14, y5: 6'd9,
                      top1: 5'd24, top2: 6'd38,
                      m1: 25'h1FFFFFF, m2: 39'h7FFFFFFFFF, reps: 2'd3};
            end
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

/* sv/katan_keysched.sv */
// 80-bit round key lfsr, stepped two bits forward or backward per cycle while fwd or back is set
// depends on katan_pkg
`default_nettype none

module katan_keysched (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire katan_pkg::ks_ctrl_t ctrl,
    input  wire logic [63:0]         key_low,
    input  wire logic [15:0]         key_high,
    output logic                     ka,
    output logic                     kb
);

    logic [katan_pkg::KEY_BITS-1:0] kw_reg;
    logic [katan_pkg::KEY_BITS-1:0] kw_next;

    function automatic logic [katan_pkg::KEY_BITS-1:0] fwd1(
        input logic [katan_pkg::KEY_BITS-1:0] w);
        logic nb;
        nb = w[0] ^ w[katan_pkg::KT_A] ^ w[katan_pkg::KT_B] ^ w[katan_pkg::KT_C];
        return {nb, w[katan_pkg::KEY_BITS-1:1]};
    endfunction

    // recover the bit that dropped out of the window on the last forward step
    function automatic logic [katan_pkg::KEY_BITS-1:0] back1(
        input logic [katan_pkg::KEY_BITS-1:0] w);
        logic nb;
        nb = w[katan_pkg::KEY_BITS-1] ^ w[katan_pkg::KT_A-1] ^ w[katan_pkg::KT_B-1]
           ^ w[katan_pkg::KT_C-1];
        return {w[katan_pkg::KEY_BITS-2:0], nb};
    endfunction

    always_comb
    begin
        kw_next = kw_reg;
        priority if (ctrl.load)
        begin
            kw_next = {key_high, key_low};
        end
        else if (ctrl.fwd)
        begin
            kw_next = fwd1(fwd1(kw_reg));
        end
        else if (ctrl.back)
        begin
            kw_next = back1(back1(kw_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kw_reg <= '0;
        end
        else
        begin
            kw_reg <= kw_next;
        end
    end

    assign ka = kw_reg[0];
    assign kb = kw_reg[1];

endmodule

`default_nettype wire

/* sv/katan_round.sv */
// cipher state registers and the shared round unit (one round per cycle while step is high)
// depends on katan_pkg
`default_nettype none

module katan_round (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [1:0]           mode,
    input  wire katan_pkg::rnd_ctrl_t ctrl,
    input  wire logic [63:0]          data_block,
    output logic [63:0]               result_block
);

    typedef struct packed {
        logic [katan_pkg::L1_W-1:0] l1;
        logic [katan_pkg::L2_W-1:0] l2;
    } regs_t;

    katan_pkg::geom_t g;
    regs_t            st_reg;
    regs_t            st_next;
    regs_t            loaded;
    regs_t            stepped;

    function automatic regs_t step_fwd(input katan_pkg::geom_t gm, input regs_t s,
                                       input logic ir, input logic ka, input logic kb);
        regs_t o;
        logic  fa;
        logic  fb;
        fa = s.l1[gm.x0] ^ s.l1[gm.x1] ^ (s.l1[gm.x2] & s.l1[gm.x3])
           ^ (s.l1[gm.x4] & ir) ^ ka;
        fb = s.l2[gm.y0] ^ s.l2[gm.y1] ^ (s.l2[gm.y2] & s.l2[gm.y3])
           ^ (s.l2[gm.y4] & s.l2[gm.y5]) ^ kb;
        o.l1 = {s.l1[katan_pkg::L1_W-2:0], fb} & gm.m1;
        o.l2 = {s.l2[katan_pkg::L2_W-2:0], fa} & gm.m2;
        return o;
    endfunction

    function automatic regs_t step_back(input katan_pkg::geom_t gm, input regs_t s,
                                        input logic ir, input logic ka, input logic kb);
        regs_t o;
        logic  t1;
        logic  t2;
        o.l1 = s.l1 >> 1;
        o.l2 = s.l2 >> 1;
        t1 = s.l2[0] ^ o.l1[gm.x1] ^ (o.l1[gm.x2] & o.l1[gm.x3])
           ^ (o.l1[gm.x4] & ir) ^ ka;
        t2 = s.l1[0] ^ o.l2[gm.y1] ^ (o.l2[gm.y2] & o.l2[gm.y3])
           ^ (o.l2[gm.y4] & o.l2[gm.y5]) ^ kb;
        o.l1[gm.top1] = t1;
        o.l2[gm.top2] = t2;
        return o;
    endfunction

    assign g = katan_pkg::geometry(mode);

    // split the block into the two nonlinear registers
    always_comb
    begin
        unique case (mode)
            katan_pkg::MODE_32:
            begin
                loaded.l1 = {12'b0, data_block[31:19]};
                loaded.l2 = {20'b0, data_block[18:0]};
            end
            katan_pkg::MODE_48:
            begin
                loaded.l1 = {6'b0, data_block[47:29]};
                loaded.l2 = {10'b0, data_block[28:0]};
            end
            default:
            begin
                loaded.l1 = data_block[63:39];
                loaded.l2 = data_block[38:0];
            end
        endcase
    end

    // one round: the update repeated once, twice or three times
    always_comb
    begin
        stepped = st_reg;
        for (int j = 0; j < 3; j++)
        begin
            if (j < int'(g.reps))
            begin
                if (ctrl.dir)
                begin
                    stepped = step_back(g, stepped, ctrl.ir, ctrl.ka, ctrl.kb);
                end
                else
                begin
                    stepped = step_fwd(g, stepped, ctrl.ir, ctrl.ka, ctrl.kb);
                end
            end
        end
    end

    always_comb
    begin
        st_next = st_reg;
        priority if (ctrl.load)
        begin
            st_next = loaded;
        end
        else if (ctrl.step)
        begin
            st_next = stepped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_comb
    begin
        unique case (mode)
            katan_pkg::MODE_32:
            begin
                result_block = {32'b0, st_reg.l1[12:0], st_reg.l2[18:0]};
            end
            katan_pkg::MODE_48:
            begin
                result_block = {16'b0, st_reg.l1[18:0], st_reg.l2[28:0]};
            end
            default:
            begin
                result_block = {st_reg.l1, st_reg.l2};
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/katan_block_cipher_core_unit.sv */
// top level of the katan 32/48/64 cipher core: config registers and round sequencer
// depends on katan_pkg, katan_keysched and katan_round
//
// usage:
//   an item (op, data_block, key_low, key_high) is taken when start is high and
//   busy is low. busy stays high until the result has been shown.
//   the result is on result_block for exactly one cycle with done high; the
//   receiver cannot stall, so the transaction completes in that cycle.
//   config writes: cfg_valid with cfg_index/cfg_data, cfg_ready is always high;
//   write only while busy is low. index 0 block size mode, 1 round count,
//   2 start round. index 3 is ignored.
// sequence: the item is loaded when it is taken, then the key rolls forward
//   (start round for encrypt, start round + rounds - 1 for decrypt), then the
//   rounds run, then done is shown. one round per cycle is set by the shared
//   round unit, the key roll by the two-bit-per-cycle key lfsr.
// a new item can be taken in the cycle after done.
// reset clears the config to 32-bit blocks, 254 rounds from round 0, and
// returns the sequencer to idle.
`default_nettype none

module katan_block_cipher_core_unit #(
    parameter int MAX_ROUNDS = katan_pkg::MAX_ROUNDS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        op,
    input  wire logic [63:0] data_block,
    input  wire logic [63:0] key_low,
    input  wire logic [15:0] key_high,
    output logic             done,
    output logic [63:0]      result_block,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    localparam logic [8:0] MaxR = 9'(MAX_ROUNDS);

    katan_pkg::state_t    state_reg;
    katan_pkg::state_t    state_next;
    katan_pkg::ks_ctrl_t  ks_ctrl;
    katan_pkg::rnd_ctrl_t rnd_ctrl;

    logic [1:0] mode_reg;
    logic [7:0] round_count_reg;
    logic [7:0] start_round_reg;

    logic [7:0] roll_left_reg;
    logic [7:0] roll_left_next;
    logic [7:0] rounds_left_reg;
    logic [7:0] rounds_left_next;
    logic [7:0] round_reg;
    logic [7:0] round_next;
    logic       dir_reg;
    logic       dir_next;

    logic       accept;
    logic [8:0] span;
    logic [7:0] cnt_eff;
    logic [7:0] roll_amt;
    logic       ka;
    logic       kb;

    assign cfg_ready = 1'b1;
    assign accept    = start && (state_reg == katan_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 2'd0;
            round_count_reg <= 8'd254;
            start_round_reg <= 8'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                katan_pkg::REG_BLOCK_SIZE_MODE: mode_reg        <= cfg_data[1:0];
                katan_pkg::REG_ROUND_COUNT:     round_count_reg <= cfg_data;
                katan_pkg::REG_START_ROUND:     start_round_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // saturate the round window at the end of the constant table
    always_comb
    begin
        span = {1'b0, start_round_reg} + {1'b0, round_count_reg};
        priority if ({1'b0, start_round_reg} >= MaxR)
        begin
            cnt_eff = 8'd0;
        end
        else if (span > MaxR)
        begin
            cnt_eff = 8'(MaxR - {1'b0, start_round_reg});
        end
        else
        begin
            cnt_eff = round_count_reg;
        end
    end

    // decryption starts from the last round of the window
    always_comb
    begin
        if (op && (cnt_eff != 8'd0))
        begin
            roll_amt = start_round_reg + cnt_eff - 8'd1;
        end
        else
        begin
            roll_amt = start_round_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            katan_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    priority if (cnt_eff == 8'd0)
                    begin
                        state_next = katan_pkg::ST_DONE;
                    end
                    else if (roll_amt == 8'd0)
                    begin
                        state_next = katan_pkg::ST_RUN;
                    end
                    else
                    begin
                        state_next = katan_pkg::ST_ROLL;
                    end
                end
            end
            katan_pkg::ST_ROLL:
            begin
                if (roll_left_reg == 8'd1)
                begin
                    state_next = katan_pkg::ST_RUN;
                end
            end
            katan_pkg::ST_RUN:
            begin
                if (rounds_left_reg == 8'd1)
                begin
                    state_next = katan_pkg::ST_DONE;
                end
            end
            katan_pkg::ST_DONE:
            begin
                state_next = katan_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = katan_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy          = (state_reg != katan_pkg::ST_IDLE);
        done          = (state_reg == katan_pkg::ST_DONE);
        ks_ctrl.load  = accept;
        ks_ctrl.fwd   = (state_reg == katan_pkg::ST_ROLL)
                     || ((state_reg == katan_pkg::ST_RUN) && !dir_reg);
        ks_ctrl.back  = (state_reg == katan_pkg::ST_RUN) && dir_reg;
        rnd_ctrl.load = accept;
        rnd_ctrl.step = (state_reg == katan_pkg::ST_RUN);
        rnd_ctrl.dir  = dir_reg;
        rnd_ctrl.ir   = katan_pkg::ir_bit(round_reg);
        rnd_ctrl.ka   = ka;
        rnd_ctrl.kb   = kb;
    end

    always_comb
    begin
        roll_left_next   = roll_left_reg;
        rounds_left_next = rounds_left_reg;
        round_next       = round_reg;
        dir_next         = dir_reg;
        if (accept)
        begin
            roll_left_next   = roll_amt;
            rounds_left_next = cnt_eff;
            round_next       = roll_amt;
            dir_next         = op;
        end
        else if (state_reg == katan_pkg::ST_ROLL)
        begin
            roll_left_next = roll_left_reg - 8'd1;
        end
        else if (state_reg == katan_pkg::ST_RUN)
        begin
            rounds_left_next = rounds_left_reg - 8'd1;
            round_next       = dir_reg ? (round_reg - 8'd1) : (round_reg + 8'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= katan_pkg::ST_IDLE;
            roll_left_reg   <= 8'd0;
            rounds_left_reg <= 8'd0;
            round_reg       <= 8'd0;
            dir_reg         <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            roll_left_reg   <= roll_left_next;
            rounds_left_reg <= rounds_left_next;
            round_reg       <= round_next;
            dir_reg         <= dir_next;
        end
    end

    katan_keysched u_keysched (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ks_ctrl),
        .key_low  (key_low),
        .key_high (key_high),
        .ka       (ka),
        .kb       (kb)
    );

    katan_round u_round (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (mode_reg),
        .ctrl         (rnd_ctrl),
        .data_block   (data_block),
        .result_block (result_block)
    );

`ifndef NO_ASSERTIONS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_roll_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == katan_pkg::ST_ROLL) |-> (roll_left_reg != 8'd0))
        else $error("key roll entered with zero count");

    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == katan_pkg::ST_RUN) |-> (rounds_left_reg != 8'd0))
        else $error("round loop entered with zero rounds left");
`endif

endmodule

`default_nettype wire
